>>> design/bfps_pkg.sv
// ----------------------------------------------------------------------------
// bfps_pkg
// Types, constants and helpers shared by the shortest-path core.
// ----------------------------------------------------------------------------
package bfps_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxEdges    = 4096;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned DistBits    = 40;
  localparam int unsigned VBits       = 10;   // vertex number
  localparam int unsigned CntBits     = 11;   // vertex count, rounds
  localparam int unsigned SlotBits    = 13;   // index and offset fields
  localparam int unsigned EAddrBits   = 12;
  localparam int unsigned EntryBits   = DistBits + 1;  // reached flag + distance
  localparam int unsigned EdgeBits    = VBits + WeightBits;

  typedef enum logic [1:0] {
    OP_LOAD_OFFSET = 2'd0,
    OP_LOAD_EDGE   = 2'd1,
    OP_RUN         = 2'd2,
    OP_QUERY       = 2'd3
  } opcode_e;

  typedef enum logic {
    CFG_VERTEX_COUNT  = 1'b0,
    CFG_SOURCE_VERTEX = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUERY,
    ST_ROUND,
    ST_OFF0,
    ST_VTX,
    ST_EDGE,
    ST_EREAD,
    ST_PREAD,
    ST_WRITE
  } state_e;

  typedef logic signed [DistBits-1:0]   dist_t;
  typedef logic signed [WeightBits-1:0] weight_t;

  // saturating distance + weight
  function automatic dist_t sat_add(input dist_t d, input weight_t w);
    logic signed [DistBits:0] s;
    begin
      s = {d[DistBits-1], d} + {{(DistBits+1-WeightBits){w[WeightBits-1]}}, w};
      if (s[DistBits] != s[DistBits-1]) begin
        sat_add = s[DistBits] ? {1'b1, {(DistBits-1){1'b0}}}
                              : {1'b0, {(DistBits-1){1'b1}}};
      end else begin
        sat_add = s[DistBits-1:0];
      end
    end
  endfunction

endpackage

>>> design/bfps_if.sv
// ----------------------------------------------------------------------------
// bfps_in_if / bfps_out_if
// Valid/ready channels carrying command and answer words.
// ----------------------------------------------------------------------------
interface bfps_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [12:0]                       index;
  logic [12:0]                       offset_value;
  logic [9:0]                        edge_source;
  logic signed [15:0]                edge_weight;

  modport source (output valid, opcode, index, offset_value, edge_source, edge_weight,
                  input ready);
  modport sink   (input valid, opcode, index, offset_value, edge_source, edge_weight,
                  output ready);
endinterface

interface bfps_out_if;
  logic                              valid;
  logic                              ready;
  logic                              answer_kind;
  logic                              reached;
  logic signed [39:0]                distance;
  logic [10:0]                       rounds_run;
  logic                              converged;

  modport source (output valid, answer_kind, reached, distance, rounds_run, converged,
                  input ready);
  modport sink   (input valid, answer_kind, reached, distance, rounds_run, converged,
                  output ready);
endinterface

>>> design/bellman_ford_pull_sssp_core.sv
// ----------------------------------------------------------------------------
// bellman_ford_pull_sssp_core
// Jacobi Bellman-Ford over incoming-edge CSR tables, one memory access a step.
// ----------------------------------------------------------------------------
// Load words are taken one a cycle while no answer word waits; a query answer is
// registered from the bank entry read in ST_QUERY. Per round each vertex is visited:
// the source is written back, others read each edge and an in-range predecessor;
// the report is valid the cycle after the last write; rounds stop at no change or
// vertex_count. Input is held off from accept until the answer word is taken.
// Reset clears control state; queries before the first run answer unreached.
module bellman_ford_pull_sssp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bfps_pkg::CntBits-1:0]  cfg_wdata_i,
  bfps_in_if.sink                       in_s,
  bfps_out_if.source                    out_s
);
  import bfps_pkg::*;

  state_e                 state_q, state_d;
  logic [CntBits-1:0]     vcnt_q;
  logic [VBits-1:0]       src_cfg_q;
  logic [CntBits-1:0]     n_q, n_d, n_last_q, n_last_d, round_q, round_d;
  logic [CntBits-1:0]     last_rounds_q, last_rounds_d;
  logic [VBits-1:0]       src_q, src_d, v_q, v_d, u_q, u_d;
  logic                   src_ok_q, src_ok_d, changed_q, changed_d;
  logic                   last_conv_q, last_conv_d, run_done_q, run_done_d;
  logic                   bank_sel_q, bank_sel_d, have_q, have_d;
  logic [SlotBits-1:0]    lo_q, lo_d, hi_q, hi_d, hi_raw_q, hi_raw_d, i_q, i_d;
  logic [SlotBits-1:0]    idx_q, idx_d;
  dist_t                  best_q, best_d, cand;
  logic [EntryBits-1:0]   orig_q, orig_d, pv, init_v;
  weight_t                w_q, w_d;
  logic                   out_valid_q, out_valid_d;
  logic                   o_kind_q, o_kind_d, o_reached_q, o_reached_d;
  dist_t                  o_dist_q, o_dist_d;
  logic [CntBits-1:0]     o_rounds_q, o_rounds_d;
  logic                   o_conv_q, o_conv_d;

  // memory ports
  logic                   off_we, edge_we, bank_we, chg_now, first;
  logic [CntBits-1:0]     off_waddr, off_raddr;
  logic [SlotBits-1:0]    off_rdata;
  logic [EAddrBits-1:0]   edge_waddr, edge_raddr;
  logic [EdgeBits-1:0]    edge_rdata;
  logic [VBits-1:0]       bank_raddr;
  logic [EntryBits-1:0]   bank_wdata, bank_a_rdata, bank_b_rdata, bank_rdata;
  logic [CntBits-1:0]     v_next;

  bfps_ram #(.Width(SlotBits), .Depth(MaxVertices + 1)) u_off_ram (
    .clk_i, .we_i(off_we), .waddr_i(off_waddr), .wdata_i(in_s.offset_value),
    .raddr_i(off_raddr), .rdata_o(off_rdata)
  );

  bfps_ram #(.Width(EdgeBits), .Depth(MaxEdges)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr),
    .wdata_i({in_s.edge_source, in_s.edge_weight}),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  // bank_sel_q selects the bank holding the previous round; the other is written
  bfps_ram #(.Width(EntryBits), .Depth(MaxVertices)) u_bank_a (
    .clk_i, .we_i(bank_we && bank_sel_q), .waddr_i(v_q), .wdata_i(bank_wdata),
    .raddr_i(bank_raddr), .rdata_o(bank_a_rdata)
  );

  bfps_ram #(.Width(EntryBits), .Depth(MaxVertices)) u_bank_b (
    .clk_i, .we_i(bank_we && !bank_sel_q), .waddr_i(v_q), .wdata_i(bank_wdata),
    .raddr_i(bank_raddr), .rdata_o(bank_b_rdata)
  );

  assign bank_rdata = bank_sel_q ? bank_b_rdata : bank_a_rdata;
  assign bank_wdata = {have_q, best_q};
  assign first      = (round_q == CntBits'(1));
  assign off_waddr  = in_s.index[CntBits-1:0];
  assign edge_waddr = in_s.index[EAddrBits-1:0];
  assign v_next     = CntBits'(v_q) + CntBits'(1);

  assign in_s.ready        = (state_q == ST_IDLE) && !out_valid_q;
  assign out_s.valid       = out_valid_q;
  assign out_s.answer_kind = o_kind_q;
  assign out_s.reached     = o_reached_q;
  assign out_s.distance    = o_dist_q;
  assign out_s.rounds_run  = o_rounds_q;
  assign out_s.converged   = o_conv_q;

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    n_last_d      = n_last_q;
    round_d       = round_q;
    last_rounds_d = last_rounds_q;
    src_d         = src_q;
    v_d           = v_q;
    u_d           = u_q;
    src_ok_d      = src_ok_q;
    changed_d     = changed_q;
    last_conv_d   = last_conv_q;
    run_done_d    = run_done_q;
    bank_sel_d    = bank_sel_q;
    have_d        = have_q;
    best_d        = best_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    hi_raw_d      = hi_raw_q;
    i_d           = i_q;
    idx_d         = idx_q;
    orig_d        = orig_q;
    w_d           = w_q;
    out_valid_d   = out_valid_q && !out_s.ready;
    o_kind_d      = o_kind_q;
    o_reached_d   = o_reached_q;
    o_dist_d      = o_dist_q;
    o_rounds_d    = o_rounds_q;
    o_conv_d      = o_conv_q;
    off_we        = 1'b0;
    edge_we       = 1'b0;
    bank_we       = 1'b0;
    off_raddr     = '0;
    edge_raddr    = i_q[EAddrBits-1:0];
    bank_raddr    = '0;
    chg_now       = 1'b0;
    cand          = '0;
    init_v        = '0;
    pv            = '0;

    unique case (state_q)
      ST_IDLE: begin
        bank_raddr = in_s.index[VBits-1:0];
        if (in_s.valid && in_s.ready) begin
          unique case (opcode_e'(in_s.opcode))
            OP_LOAD_OFFSET: off_we = (in_s.index <= SlotBits'(MaxVertices));
            OP_LOAD_EDGE:   edge_we = (in_s.index < SlotBits'(MaxEdges));
            OP_RUN: begin
              if (vcnt_q == '0) begin
                n_d = CntBits'(1);
              end else if (vcnt_q > CntBits'(MaxVertices)) begin
                n_d = CntBits'(MaxVertices);
              end else begin
                n_d = vcnt_q;
              end
              src_d    = src_cfg_q;
              src_ok_d = (CntBits'(src_cfg_q) < n_d);
              round_d  = '0;
              state_d  = ST_ROUND;
            end
            OP_QUERY: begin
              idx_d   = in_s.index;
              state_d = ST_QUERY;
            end
            default: ;
          endcase
        end
      end
      ST_QUERY: begin
        out_valid_d = 1'b1;
        o_kind_d    = 1'b1;
        o_reached_d = run_done_q && (idx_q < SlotBits'(n_last_q)) && bank_rdata[DistBits];
        o_dist_d    = o_reached_d ? bank_rdata[DistBits-1:0] : '0;
        o_rounds_d  = last_rounds_q;
        o_conv_d    = last_conv_q;
        state_d     = ST_IDLE;
      end
      ST_ROUND: begin
        round_d   = round_q + CntBits'(1);
        changed_d = 1'b0;
        v_d       = '0;
        off_raddr = '0;
        state_d   = ST_OFF0;
      end
      ST_OFF0: begin
        lo_d       = off_rdata;
        off_raddr  = CntBits'(1);
        bank_raddr = '0;
        state_d    = ST_VTX;
      end
      ST_VTX: begin
        init_v[DistBits] = src_ok_q && (v_q == src_q);
        orig_d   = first ? init_v : bank_rdata;
        have_d   = orig_d[DistBits];
        best_d   = orig_d[DistBits-1:0];
        hi_raw_d = off_rdata;
        hi_d     = (off_rdata > SlotBits'(MaxEdges)) ? SlotBits'(MaxEdges) : off_rdata;
        i_d      = lo_q;
        state_d  = (v_q == src_q) ? ST_WRITE : ST_EDGE;
      end
      ST_EDGE: begin
        edge_raddr = i_q[EAddrBits-1:0];
        state_d    = (i_q < hi_q) ? ST_EREAD : ST_WRITE;
      end
      ST_EREAD: begin
        u_d = edge_rdata[EdgeBits-1:WeightBits];
        w_d = edge_rdata[WeightBits-1:0];
        bank_raddr = u_d;
        if (CntBits'(u_d) < n_q) begin
          state_d = ST_PREAD;
        end else begin
          i_d     = i_q + SlotBits'(1);
          state_d = ST_EDGE;
        end
      end
      ST_PREAD: begin
        init_v[DistBits] = src_ok_q && (u_q == src_q);
        pv   = first ? init_v : bank_rdata;
        cand = sat_add(pv[DistBits-1:0], w_q);
        if (pv[DistBits] && (!have_q || cand < best_q)) begin
          have_d = 1'b1;
          best_d = cand;
        end
        i_d     = i_q + SlotBits'(1);
        state_d = ST_EDGE;
      end
      ST_WRITE: begin
        bank_we   = 1'b1;
        chg_now   = changed_q || (bank_wdata != orig_q);
        changed_d = chg_now;
        lo_d      = hi_raw_q;
        if (v_next < n_q) begin
          v_d        = v_next[VBits-1:0];
          off_raddr  = v_next + CntBits'(1);
          bank_raddr = v_next[VBits-1:0];
          state_d    = ST_VTX;
        end else begin
          bank_sel_d = !bank_sel_q;
          if (chg_now && (round_q < n_q)) begin
            state_d = ST_ROUND;
          end else begin
            last_rounds_d = round_q;
            last_conv_d   = !chg_now;
            run_done_d    = 1'b1;
            n_last_d      = n_q;
            out_valid_d   = 1'b1;
            o_kind_d      = 1'b0;
            o_reached_d   = 1'b0;
            o_dist_d      = '0;
            o_rounds_d    = round_q;
            o_conv_d      = !chg_now;
            state_d       = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      vcnt_q        <= CntBits'(1);
      src_cfg_q     <= '0;
      last_rounds_q <= '0;
      last_conv_q   <= 1'b0;
      run_done_q    <= 1'b0;
      bank_sel_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      round_q       <= '0;
      n_q           <= CntBits'(1);
      n_last_q      <= '0;
    end else begin
      state_q       <= state_d;
      last_rounds_q <= last_rounds_d;
      last_conv_q   <= last_conv_d;
      run_done_q    <= run_done_d;
      bank_sel_q    <= bank_sel_d;
      out_valid_q   <= out_valid_d;
      round_q       <= round_d;
      n_q           <= n_d;
      n_last_q      <= n_last_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_VERTEX_COUNT:  vcnt_q    <= cfg_wdata_i;
          CFG_SOURCE_VERTEX: src_cfg_q <= cfg_wdata_i[VBits-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    v_q         <= v_d;
    u_q         <= u_d;
    src_ok_q    <= src_ok_d;
    changed_q   <= changed_d;
    have_q      <= have_d;
    best_q      <= best_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    hi_raw_q    <= hi_raw_d;
    i_q         <= i_d;
    idx_q       <= idx_d;
    orig_q      <= orig_d;
    w_q         <= w_d;
    o_kind_q    <= o_kind_d;
    o_reached_q <= o_reached_d;
    o_dist_q    <= o_dist_d;
    o_rounds_q  <= o_rounds_d;
    o_conv_q    <= o_conv_d;
  end
endmodule

>>> design/bfps_ram.sv
// ----------------------------------------------------------------------------
// bfps_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bellman_ford_pull_sssp_core: loads small CSR graphs,
// runs shortest-path passes and queries vertices, predicting every answer
// word with an in-bench Jacobi Bellman-Ford and checking it field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfps_pkg::*;

  localparam longint DMAX = (64'sd1 <<< (DistBits - 1)) - 1;
  localparam longint DMIN = -DMAX - 1;

  typedef struct packed {
    logic              kind;
    logic              reached;
    logic [39:0]       distance;
    logic [10:0]       rounds;
    logic              converged;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CntBits-1:0] cfg_wdata_i = '0;

  bfps_in_if  in_if ();
  bfps_out_if out_if ();

  bellman_ford_pull_sssp_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_s (in_if), .out_s (out_if)
  );

  // predictor state
  int unsigned     vtx_count = 1, src_vtx = 0;
  logic [12:0]     offsets  [0:MaxVertices];
  logic [9:0]      e_src    [0:MaxEdges-1];
  logic [15:0]     e_wt     [0:MaxEdges-1];
  bit              cur_r    [0:MaxVertices-1];
  longint          cur_d    [0:MaxVertices-1];
  int unsigned     last_rounds = 0;
  bit              last_conv = 1'b0;

  answer_t         pending_answers [$];
  int              mismatches = 0;
  int              items_sent = 0;
  bit              no_gaps = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic longint dist_sat(longint d, longint w);
    longint s;
    s = d + w;
    if (s > DMAX) return DMAX;
    if (s < DMIN) return DMIN;
    return s;
  endfunction

  function automatic void relax_graph();
    int unsigned n, hi, rnd, u;
    bit prv_r [0:MaxVertices-1];
    longint prv_d [0:MaxVertices-1];
    bit changed, have;
    longint best, cand;
    n = (vtx_count < 1) ? 1 : (vtx_count > MaxVertices) ? MaxVertices : vtx_count;
    foreach (cur_r[i]) begin
      cur_r[i] = 1'b0;
      cur_d[i] = 0;
    end
    if (src_vtx < n) cur_r[src_vtx] = 1'b1;
    rnd = 0;
    do begin
      prv_r = cur_r;
      prv_d = cur_d;
      changed = 1'b0;
      rnd++;
      for (int unsigned v = 0; v < n; v++) begin
        if (v == src_vtx) continue;
        have = cur_r[v];
        best = cur_d[v];
        hi = offsets[v+1];
        if (hi > MaxEdges) hi = MaxEdges;
        for (int unsigned i = offsets[v]; i < hi; i++) begin
          u = e_src[i];
          if (u >= n || !prv_r[u]) continue;
          cand = dist_sat(prv_d[u], longint'($signed(e_wt[i])));
          if (!have || cand < best) begin
            have = 1'b1;
            best = cand;
          end
        end
        if (have != cur_r[v] || best != cur_d[v]) begin
          cur_r[v] = have;
          cur_d[v] = best;
          changed = 1'b1;
        end
      end
    end while (changed && rnd < n);
    last_rounds = rnd;
    last_conv = !changed;
  endfunction

  function automatic void predict_word(opcode_e op, int unsigned idx, logic [12:0] off,
                                       logic [9:0] es, logic [15:0] w);
    answer_t a;
    case (op)
      OP_LOAD_OFFSET: begin
        if (idx <= MaxVertices) offsets[idx] = off;
        return;
      end
      OP_LOAD_EDGE: begin
        if (idx < MaxEdges) begin
          e_src[idx] = es;
          e_wt[idx]  = w;
        end
        return;
      end
      default: ;
    endcase
    a = '0;
    if (op == OP_RUN) relax_graph();
    else begin
      a.kind = 1'b1;
      if (idx < MaxVertices && cur_r[idx]) begin
        a.reached  = 1'b1;
        a.distance = cur_d[idx][39:0];
      end
    end
    a.rounds    = last_rounds[10:0];
    a.converged = last_conv;
    pending_answers = {pending_answers, a};
  endfunction

  // caller sits at a falling edge; returns at the falling edge after the accept
  task automatic send_word(opcode_e op, int unsigned idx, logic [12:0] off = '0,
                           logic [9:0] es = '0, logic [15:0] w = '0);
    repeat (gap_len()) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.opcode       = op;
    in_if.index        = idx[12:0];
    in_if.offset_value = off;
    in_if.edge_source  = es;
    in_if.edge_weight  = w;
    do @(posedge clk_i); while (!in_if.ready);
    predict_word(op, idx, off, es, w);
    if (!((op == OP_LOAD_OFFSET && idx > MaxVertices) ||
          (op == OP_LOAD_EDGE && idx >= MaxEdges))) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, int unsigned val);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = r;
    cfg_wdata_i = val[10:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (r == CFG_VERTEX_COUNT) vtx_count = val[10:0];
    else src_vtx = val[9:0];
  endtask

  task automatic query_all(int unsigned n);
    for (int unsigned v = 0; v <= n; v++) send_word(OP_QUERY, v);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_query_before_run();
    send_word(OP_QUERY, 0);
    send_word(OP_QUERY, 8191);
  endtask

  task automatic test_large_graph();
    // every offset zero: no edges, so a wide pass converges in one round
    for (int unsigned s = 0; s <= 256; s++) send_word(OP_LOAD_OFFSET, s, 13'd0);
    write_reg(CFG_VERTEX_COUNT, 256);
    write_reg(CFG_SOURCE_VERTEX, 255);
    send_word(OP_RUN, 0);
    send_word(OP_QUERY, 255);
    send_word(OP_QUERY, 256);
    write_reg(CFG_VERTEX_COUNT, 0);
    send_word(OP_RUN, 0);
    send_word(OP_QUERY, 0);
    write_reg(CFG_VERTEX_COUNT, 256);
    write_reg(CFG_SOURCE_VERTEX, 0);
    send_word(OP_RUN, 0);
    send_word(OP_QUERY, 0);
  endtask

  task automatic test_edge_cases();
    // edges near the table end; vertex 3 has an end below its start,
    // vertex 4 runs past the last slot and is cut there
    write_reg(CFG_VERTEX_COUNT, 5);
    send_word(OP_LOAD_EDGE, 4090, 13'd0, 10'd0,   16'h7fff);
    send_word(OP_LOAD_EDGE, 4091, 13'd0, 10'd900, 16'h8000);
    send_word(OP_LOAD_EDGE, 4092, 13'd0, 10'd1,   16'h8000);
    send_word(OP_LOAD_EDGE, 4093, 13'd0, 10'd4,   16'd3);
    send_word(OP_LOAD_EDGE, 4094, 13'd0, 10'd2,   16'hffff);
    send_word(OP_LOAD_EDGE, 4095, 13'd0, 10'd1023, 16'd7);
    send_word(OP_LOAD_EDGE, 8191, 13'd0, 10'h3ff, 16'hffff);
    send_word(OP_LOAD_OFFSET, 0, 13'd4090);
    send_word(OP_LOAD_OFFSET, 1, 13'd4090);
    send_word(OP_LOAD_OFFSET, 2, 13'd4092);
    send_word(OP_LOAD_OFFSET, 3, 13'd4095);
    send_word(OP_LOAD_OFFSET, 4, 13'd4094);
    send_word(OP_LOAD_OFFSET, 5, 13'd5000);
    send_word(OP_LOAD_OFFSET, 8191, 13'h1fff);
    send_word(OP_RUN, 0);
    query_all(5);
    write_reg(CFG_SOURCE_VERTEX, 1023);
    send_word(OP_RUN, 0);
    send_word(OP_QUERY, 0);
    write_reg(CFG_SOURCE_VERTEX, 3);
    send_word(OP_RUN, 0);
    query_all(4);
  endtask

  task automatic test_negative_cycle();
    write_reg(CFG_VERTEX_COUNT, 3);
    write_reg(CFG_SOURCE_VERTEX, 0);
    send_word(OP_LOAD_EDGE, 0, 13'd0, 10'd0, 16'd1);
    send_word(OP_LOAD_EDGE, 1, 13'd0, 10'd2, 16'd1);
    send_word(OP_LOAD_EDGE, 2, 13'd0, 10'd1, -16'sd5);
    send_word(OP_LOAD_OFFSET, 1, 13'd0);
    send_word(OP_LOAD_OFFSET, 2, 13'd2);
    send_word(OP_LOAD_OFFSET, 3, 13'd3);
    send_word(OP_RUN, 0);
    query_all(3);
  endtask

  task automatic load_random_graph(int unsigned n);
    int unsigned base, slot, cnt;
    logic [15:0] w;
    logic [9:0]  es;
    base = $urandom_range(0, MaxEdges - 4 * n - 1);
    slot = base;
    send_word(OP_LOAD_OFFSET, 0, base[12:0]);
    for (int unsigned v = 0; v < n; v++) begin
      cnt = $urandom_range(0, 3);
      for (int unsigned k = 0; k < cnt; k++) begin
        w = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                        : 16'($urandom_range(0, 200)) - 16'd40;
        es = ($urandom_range(0, 7) == 0) ? 10'($urandom()) : 10'($urandom_range(0, n - 1));
        send_word(OP_LOAD_EDGE, slot, 13'($urandom()), es, w);
        slot++;
      end
      send_word(OP_LOAD_OFFSET, v + 1, slot[12:0]);
      // stray writes outside both tables are ignored by the block
      if ($urandom_range(0, 5) == 0)
        send_word(OP_LOAD_OFFSET, $urandom_range(MaxVertices + 1, 8191), 13'($urandom()));
      if ($urandom_range(0, 5) == 0)
        send_word(OP_LOAD_EDGE, $urandom_range(MaxEdges, 8191), 13'($urandom()),
                  10'($urandom()), 16'($urandom()));
    end
  endtask

  task automatic test_random();
    int unsigned n;
    while (items_sent < 500) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 8);
      write_reg(CFG_VERTEX_COUNT, n);
      write_reg(CFG_SOURCE_VERTEX, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                               : $urandom_range(0, n - 1));
      load_random_graph(n);
      repeat ($urandom_range(1, 2)) begin
        send_word(OP_RUN, 0);
        repeat ($urandom_range(3, 10))
          send_word(OP_QUERY, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                          : $urandom_range(0, n));
        if ($urandom_range(0, 2) == 0)
          write_reg(CFG_SOURCE_VERTEX, $urandom_range(0, n - 1));
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- sink side
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else begin
        out_if.ready = 1'b1;
        hold = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.answer_kind, out_if.reached, out_if.distance, out_if.rounds_run,
             out_if.converged};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer word %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d rch %0d/%0d dist %0d/%0d rnd %0d/%0d cnv %0d/%0d",
                     want.kind, got.kind, want.reached, got.reached,
                     $signed(want.distance), $signed(got.distance),
                     want.rounds, got.rounds, want.converged, got.converged);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_LOAD_OFFSET;
    in_if.index        = '0;
    in_if.offset_value = '0;
    in_if.edge_source  = '0;
    in_if.edge_weight  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_query_before_run();
    test_large_graph();
    test_edge_cases();
    test_negative_cycle();
    test_random();
    in_if.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
